// ===== hw/rtl/acol_pkg.sv =====
// Shared types, constants and saturation helper for the box push-out block.
`default_nettype none

package acol_pkg;

  // Width of the exact intermediate results (a 32 x 17 signed product).
  localparam int WIDE_W = 49;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 49'sh0_0000_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -49'sh0_0000_8000_0000;

  // Push-out margin: 0.01 rounded to Q.8.
  localparam logic signed [WIDE_W-1:0] PUSH_EPS = 49'sd3;

  // Register indexes on the configuration port.
  localparam logic REG_PLAYER_RADIUS = 1'b0;

  typedef enum logic {
    KIND_START  = 1'b0,
    KIND_OBJECT = 1'b1
  } kind_t;

  // Classified item handed from the front to the back.
  // For a start item lo_x/lo_y/lo_z carry the target point.
  typedef struct packed {
    kind_t              kind;
    logic               last;
    logic signed [31:0] lo_x;
    logic signed [31:0] hi_x;
    logic signed [31:0] lo_y;
    logic signed [31:0] hi_y;
    logic signed [31:0] lo_z;
    logic signed [31:0] hi_z;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] adj_x;
    logic signed [31:0] adj_y;
    logic signed [31:0] adj_z;
    logic               collided;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/acol_fifo.sv =====
// Small register-based first-in first-out queue.
`default_nettype none

module acol_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/acol_front.sv =====
// Front pipeline: scales, offsets, orders and grows each object box.
`default_nettype none

module acol_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               req_type,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic        [15:0] obj_scale,
  input  wire logic signed [31:0] min_x,
  input  wire logic signed [31:0] min_y,
  input  wire logic signed [31:0] min_z,
  input  wire logic signed [31:0] max_x,
  input  wire logic signed [31:0] max_y,
  input  wire logic signed [31:0] max_z,
  input  wire logic               last,
  input  wire logic        [15:0] player_radius,
  input  wire logic               cmd_full,
  output logic                    cmd_push,
  output acol_pkg::cmd_t          cmd_data
);

  localparam int W = acol_pkg::WIDE_W;

  logic adv;

  // Stage 1: scaled model corners, exact.
  logic                s1_valid;
  acol_pkg::kind_t     s1_kind;
  logic                s1_last;
  logic signed [31:0]  s1_pos [3];
  logic signed [W-1:0] s1_pmin [3];
  logic signed [W-1:0] s1_pmax [3];

  // Stage 2: offset corners.
  logic                s2_valid;
  acol_pkg::kind_t     s2_kind;
  logic                s2_last;
  logic signed [31:0]  s2_a [3];
  logic signed [31:0]  s2_b [3];

  // Stage 3: grown box, ready for the queue.
  logic                s3_valid;
  acol_pkg::cmd_t      s3_cmd;

  logic signed [31:0]  in_pos [3];
  logic signed [31:0]  in_min [3];
  logic signed [31:0]  in_max [3];
  logic signed [16:0]  scale_s;
  logic signed [31:0]  c_a [3];
  logic signed [31:0]  c_b [3];
  logic signed [31:0]  g_lo [3];
  logic signed [31:0]  g_hi [3];
  logic signed [W-1:0] rad_w;

  assign in_pos = '{pos_x, pos_y, pos_z};
  assign in_min = '{min_x, min_y, min_z};
  assign in_max = '{max_x, max_y, max_z};
  assign scale_s = $signed({1'b0, obj_scale});
  assign rad_w   = $signed(W'(player_radius));

  // The whole pipeline holds while its last stage cannot enter the queue.
  assign adv      = !(s3_valid && cmd_full);
  assign full     = !adv;
  assign cmd_push = s3_valid && !cmd_full;
  assign cmd_data = s3_cmd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_a[i] = acol_pkg::sat32(W'(s1_pos[i])
                 + W'(acol_pkg::sat32(s1_pmin[i] >>> 8)));
      c_b[i] = acol_pkg::sat32(W'(s1_pos[i])
                 + W'(acol_pkg::sat32(s1_pmax[i] >>> 8)));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s2_a[i] < s2_b[i]) begin
        g_lo[i] = acol_pkg::sat32(W'(s2_a[i]) - rad_w);
        g_hi[i] = acol_pkg::sat32(W'(s2_b[i]) + rad_w);
      end else begin
        g_lo[i] = acol_pkg::sat32(W'(s2_b[i]) - rad_w);
        g_hi[i] = acol_pkg::sat32(W'(s2_a[i]) + rad_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= push;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind <= acol_pkg::kind_t'(req_type);
      s1_last <= last;
      for (int i = 0; i < 3; i++) begin
        s1_pos[i]  <= in_pos[i];
        s1_pmin[i] <= W'(in_min[i]) * W'(scale_s);
        s1_pmax[i] <= W'(in_max[i]) * W'(scale_s);
      end

      s2_kind <= s1_kind;
      s2_last <= s1_last;
      for (int i = 0; i < 3; i++) begin
        // A start item carries its target point through the a slots.
        s2_a[i] <= (s1_kind == acol_pkg::KIND_START) ? s1_pos[i] : c_a[i];
        s2_b[i] <= c_b[i];
      end

      s3_cmd.kind <= s2_kind;
      s3_cmd.last <= s2_last;
      if (s2_kind == acol_pkg::KIND_START) begin
        s3_cmd.lo_x <= s2_a[0];
        s3_cmd.lo_y <= s2_a[1];
        s3_cmd.lo_z <= s2_a[2];
      end else begin
        s3_cmd.lo_x <= g_lo[0];
        s3_cmd.lo_y <= g_lo[1];
        s3_cmd.lo_z <= g_lo[2];
      end
      s3_cmd.hi_x <= g_hi[0];
      s3_cmd.hi_y <= g_hi[1];
      s3_cmd.hi_z <= g_hi[2];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/acol_back.sv =====
// Back end: tests the running point against each box and pushes it out.
`default_nettype none

module acol_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_empty,
  input  acol_pkg::cmd_t  cmd_data,
  output logic            cmd_pop,
  input  wire logic       res_full,
  output logic            res_push,
  output acol_pkg::res_t  res_data
);

  localparam int W = acol_pkg::WIDE_W;

  typedef enum logic {
    B_IDLE,
    B_EVAL
  } state_t;

  typedef enum logic [1:0] {
    SIDE_LEFT,
    SIDE_RIGHT,
    SIDE_BACK,
    SIDE_FRONT
  } side_t;

  state_t             state;
  state_t             state_next;

  logic signed [31:0] run_x;
  logic signed [31:0] run_y;
  logic signed [31:0] run_z;
  logic               hit_flag;
  logic signed [31:0] run_x_next;
  logic signed [31:0] run_y_next;
  logic signed [31:0] run_z_next;
  logic               hit_flag_next;

  // Registered first half of an object evaluation.
  logic               ev_inside;
  logic               ev_last;
  logic signed [32:0] ev_dl;
  logic signed [32:0] ev_dr;
  logic signed [32:0] ev_db;
  logic signed [32:0] ev_df;
  logic signed [31:0] ev_cl;
  logic signed [31:0] ev_cr;
  logic signed [31:0] ev_cb;
  logic signed [31:0] ev_cf;

  logic               load_eval;
  logic               in_box;
  logic signed [32:0] m_val;
  side_t              side;

  assign in_box = (run_x >= cmd_data.lo_x) && (run_x <= cmd_data.hi_x)
               && (run_y >= cmd_data.lo_y) && (run_y <= cmd_data.hi_y)
               && (run_z >= cmd_data.lo_z) && (run_z <= cmd_data.hi_z);

  // Nearest face, earlier side wins on a tie.
  always_comb begin
    m_val = ev_dl;
    side  = SIDE_LEFT;
    if (ev_dr < m_val) begin
      m_val = ev_dr;
      side  = SIDE_RIGHT;
    end
    if (ev_db < m_val) begin
      m_val = ev_db;
      side  = SIDE_BACK;
    end
    if (ev_df < m_val) begin
      side  = SIDE_FRONT;
    end
  end

  always_comb begin
    state_next    = state;
    run_x_next    = run_x;
    run_y_next    = run_y;
    run_z_next    = run_z;
    hit_flag_next = hit_flag;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    load_eval     = 1'b0;
    case (state)
      B_IDLE: begin
        if (!cmd_empty) begin
          if (cmd_data.kind == acol_pkg::KIND_START) begin
            if (!(cmd_data.last && res_full)) begin
              cmd_pop       = 1'b1;
              run_x_next    = cmd_data.lo_x;
              run_y_next    = cmd_data.lo_y;
              run_z_next    = cmd_data.lo_z;
              hit_flag_next = 1'b0;
              res_push      = cmd_data.last;
            end
          end else begin
            cmd_pop    = 1'b1;
            load_eval  = 1'b1;
            state_next = B_EVAL;
          end
        end
      end
      B_EVAL: begin
        if (!(ev_last && res_full)) begin
          if (ev_inside) begin
            hit_flag_next = 1'b1;
            case (side)
              SIDE_LEFT:  run_x_next = ev_cl;
              SIDE_RIGHT: run_x_next = ev_cr;
              SIDE_BACK:  run_y_next = ev_cb;
              SIDE_FRONT: run_y_next = ev_cf;
              default:    run_x_next = run_x;
            endcase
          end
          res_push   = ev_last;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  assign res_data.adj_x    = run_x_next;
  assign res_data.adj_y    = run_y_next;
  assign res_data.adj_z    = run_z_next;
  assign res_data.collided = hit_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      run_x    <= '0;
      run_y    <= '0;
      run_z    <= '0;
      hit_flag <= 1'b0;
    end else begin
      state    <= state_next;
      run_x    <= run_x_next;
      run_y    <= run_y_next;
      run_z    <= run_z_next;
      hit_flag <= hit_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_eval) begin
      ev_inside <= in_box;
      ev_last   <= cmd_data.last;
      ev_dl     <= 33'(run_x) - 33'(cmd_data.lo_x);
      ev_dr     <= 33'(cmd_data.hi_x) - 33'(run_x);
      ev_db     <= 33'(run_y) - 33'(cmd_data.lo_y);
      ev_df     <= 33'(cmd_data.hi_y) - 33'(run_y);
      ev_cl     <= acol_pkg::sat32(W'(cmd_data.lo_x) - acol_pkg::PUSH_EPS);
      ev_cr     <= acol_pkg::sat32(W'(cmd_data.hi_x) + acol_pkg::PUSH_EPS);
      ev_cb     <= acol_pkg::sat32(W'(cmd_data.lo_y) - acol_pkg::PUSH_EPS);
      ev_cf     <= acol_pkg::sat32(W'(cmd_data.hi_y) + acol_pkg::PUSH_EPS);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_pushout_collision.sv =====
// Top level of the point-versus-box push-out block.
`default_nettype none

//  Channel     Direction  Handshake                  Carries
//  config      in/out     APB psel/penable/pready    player_radius at byte 0
//  items       in         push / full                req_type, pos, scale, box, last
//  results     out        pop / empty                adj_x/y/z, collided
//
//  An item enters every cycle while full is low. A three-stage front scales,
//  offsets, orders and grows the box, passing an item through its s1, s2 and
//  s3 registers before it enters the command queue. The back handles a start
//  item in its idle state and an object item in idle and then eval: the
//  containment test and push-out depend on the point left by the previous box,
//  so the back takes no new object item before the last one is through. Reset
//  is synchronous and empties both queues. The front stalls only when the
//  command queue is full, the back only when a result is due and the result queue is full.

module aabb_pushout_collision #(
  parameter int CMD_DEPTH = 4,
  parameter int RES_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic        [2:0]  paddr,
  input  wire logic        [31:0] pwdata,
  output logic             [31:0] prdata,
  output logic                    pready,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               req_type,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic        [15:0] obj_scale,
  input  wire logic signed [31:0] min_x,
  input  wire logic signed [31:0] min_y,
  input  wire logic signed [31:0] min_z,
  input  wire logic signed [31:0] max_x,
  input  wire logic signed [31:0] max_y,
  input  wire logic signed [31:0] max_z,
  input  wire logic               last,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed      [31:0] adj_x,
  output logic signed      [31:0] adj_y,
  output logic signed      [31:0] adj_z,
  output logic                    collided
);

  logic [15:0]    player_radius;
  logic           cfg_wr;

  logic           cmd_push;
  logic           cmd_full;
  logic           cmd_pop;
  logic           cmd_empty;
  acol_pkg::cmd_t cmd_in;
  acol_pkg::cmd_t cmd_out;

  logic           res_push;
  logic           res_full;
  acol_pkg::res_t res_in;
  acol_pkg::res_t res_out;

  // Configuration port. The register index is the word address; a transfer
  // to a word beyond the register list is accepted and ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == acol_pkg::REG_PLAYER_RADIUS) ? 32'(player_radius) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_radius <= 16'd128;
    end else if (cfg_wr && (paddr[2] == acol_pkg::REG_PLAYER_RADIUS)) begin
      player_radius <= pwdata[15:0];
    end
  end

  // Front: box transform, running ahead of the serial push-out loop.
  acol_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .obj_scale    (obj_scale),
    .min_x        (min_x),
    .min_y        (min_y),
    .min_z        (min_z),
    .max_x        (max_x),
    .max_y        (max_y),
    .max_z        (max_z),
    .last         (last),
    .player_radius(player_radius),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_in)
  );

  // Command queue decouples the front from the back.
  acol_fifo #(
    .WIDTH($bits(acol_pkg::cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_data(cmd_in),
    .full   (cmd_full),
    .rd_en  (cmd_pop),
    .rd_data(cmd_out),
    .empty  (cmd_empty)
  );

  // Back: owns the running point and the hit flag.
  acol_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd_data (cmd_out),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_in)
  );

  // Result queue: the oldest waiting result sits on the result ports.
  acol_fifo #(
    .WIDTH($bits(acol_pkg::res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res_in),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(res_out),
    .empty  (empty)
  );

  assign adj_x    = res_out.adj_x;
  assign adj_y    = res_out.adj_y;
  assign adj_z    = res_out.adj_z;
  assign collided = res_out.collided;

  // The front never offers a box to a full command queue.
  a_cmd_no_overflow : assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command queue written while full");

  // The back never takes a command from an empty queue.
  a_cmd_no_underflow : assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command queue read while empty");

  // A result is only produced when the result queue has room for it.
  a_res_no_overflow : assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue written while full");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the box push-out block: directed rows, then random queries.
`timescale 1ns / 1ps

module testbench;

  // ---------------------------------------------------------------------------
  // Constants
  // ---------------------------------------------------------------------------
  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  // Push-out margin in Q.8 units.
  localparam longint PUSH_MARGIN = 3;
  localparam logic [15:0] RADIUS_AT_RESET = 16'd128;
  // The radius register is register 0, so it sits at byte address 0.
  localparam logic [2:0] RADIUS_ADDR = 3'(4 * int'(acol_pkg::REG_PLAYER_RADIUS));
  // Three front stages, the back's idle and eval states and the queues, with margin.
  localparam int DRAIN_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  // Length of the deliberate hold-off on the result side.
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int RANDOM_ITEMS_PER_PHASE = 305;

  typedef struct {
    acol_pkg::kind_t    kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic        [15:0] scale;
    logic signed [31:0] mnx;
    logic signed [31:0] mny;
    logic signed [31:0] mnz;
    logic signed [31:0] mxx;
    logic signed [31:0] mxy;
    logic signed [31:0] mxz;
    logic               last;
  } query_item_t;

  typedef struct {
    query_item_t    item;
    bit             typed;
    acol_pkg::res_t want;
  } directed_row_t;

  // ---------------------------------------------------------------------------
  // Signals and the block under test
  // ---------------------------------------------------------------------------
  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic        [2:0]  paddr;
  logic        [31:0] pwdata;
  logic        [31:0] prdata;
  logic               pready;
  logic               push;
  logic               full;
  logic               req_type;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        [15:0] obj_scale;
  logic signed [31:0] min_x;
  logic signed [31:0] min_y;
  logic signed [31:0] min_z;
  logic signed [31:0] max_x;
  logic signed [31:0] max_y;
  logic signed [31:0] max_z;
  logic               last;
  logic               empty;
  logic               pop;
  logic signed [31:0] adj_x;
  logic signed [31:0] adj_y;
  logic signed [31:0] adj_z;
  logic               collided;

  aabb_pushout_collision u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .obj_scale (obj_scale),
    .min_x     (min_x),
    .min_y     (min_y),
    .min_z     (min_z),
    .max_x     (max_x),
    .max_y     (max_y),
    .max_z     (max_z),
    .last      (last),
    .empty     (empty),
    .pop       (pop),
    .adj_x     (adj_x),
    .adj_y     (adj_y),
    .adj_z     (adj_z),
    .collided  (collided)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: the running point, the hit flag and the radius register.
  // These mirror what the block should hold after every accepted transfer.
  // ---------------------------------------------------------------------------
  logic signed [31:0] pt_x = '0;
  logic signed [31:0] pt_y = '0;
  logic signed [31:0] pt_z = '0;
  bit                 pt_hit = 1'b0;
  logic        [15:0] radius = RADIUS_AT_RESET;

  acol_pkg::res_t expected_points[$];
  directed_row_t  directed_rows[$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  hits_seen = 0;
  int  radius_writes = 0;
  int  idle_cycles = 0;
  int  sender_burst = 0;
  bit  saw_full = 1'b0;

  // ---------------------------------------------------------------------------
  // Fixed-point helpers for the predictor
  // ---------------------------------------------------------------------------
  function automatic longint clamp_q23(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Scales a model corner, rounding the exact product toward minus infinity,
  // and offsets it by the object position. Both steps saturate.
  function automatic longint box_corner(input longint pos, input longint model,
                                        input longint scale);
    longint prod;
    prod = model * scale;
    return clamp_q23(pos + clamp_q23(prod >>> 8));
  endfunction

  // One axis of the grown box: order the two corners, then widen by the radius.
  function automatic void grow_axis(input longint pos, input longint mn, input longint mx,
                                    input longint scale, input longint rad,
                                    output longint lo, output longint hi);
    longint a;
    longint b;
    a = box_corner(pos, mn, scale);
    b = box_corner(pos, mx, scale);
    lo = clamp_q23(((a < b) ? a : b) - rad);
    hi = clamp_q23(((a < b) ? b : a) + rad);
  endfunction

  // Advances the running point by one item and says whether a result follows.
  function automatic void step_pushout(input query_item_t it, output bit emits,
                                       output acol_pkg::res_t r);
    longint rad;
    longint lx, hx, ly, hy, lz, hz;
    longint qx, qy, qz;
    longint dl, dr, db, df, m;
    rad = longint'(radius);
    if (it.kind == acol_pkg::KIND_START) begin
      pt_x = it.px;
      pt_y = it.py;
      pt_z = it.pz;
      pt_hit = 1'b0;
    end else begin
      grow_axis(it.px, it.mnx, it.mxx, longint'(it.scale), rad, lx, hx);
      grow_axis(it.py, it.mny, it.mxy, longint'(it.scale), rad, ly, hy);
      grow_axis(it.pz, it.mnz, it.mxz, longint'(it.scale), rad, lz, hz);
      qx = pt_x;
      qy = pt_y;
      qz = pt_z;
      // Inclusive containment on all three axes; z only gates the test.
      if (qx >= lx && qx <= hx && qy >= ly && qy <= hy && qz >= lz && qz <= hz) begin
        dl = qx - lx;
        dr = hx - qx;
        db = qy - ly;
        df = hy - qy;
        m = dl;
        if (dr < m) m = dr;
        if (db < m) m = db;
        if (df < m) m = df;
        // Ties go to the first face in the order left, right, back, front.
        if (m == dl) begin
          pt_x = 32'(clamp_q23(lx - PUSH_MARGIN));
        end else if (m == dr) begin
          pt_x = 32'(clamp_q23(hx + PUSH_MARGIN));
        end else if (m == db) begin
          pt_y = 32'(clamp_q23(ly - PUSH_MARGIN));
        end else begin
          pt_y = 32'(clamp_q23(hy + PUSH_MARGIN));
        end
        pt_hit = 1'b1;
      end
    end
    emits = it.last;
    r = {pt_x, pt_y, pt_z, pt_hit};
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic query_item_t mk_item(input acol_pkg::kind_t k,
      input logic signed [31:0] px,
      input logic signed [31:0] py, input logic signed [31:0] pz, input logic [15:0] sc,
      input logic signed [31:0] mnx, input logic signed [31:0] mny,
      input logic signed [31:0] mnz, input logic signed [31:0] mxx,
      input logic signed [31:0] mxy, input logic signed [31:0] mxz, input logic lst);
    query_item_t it;
    it.kind = k;
    it.px = px;
    it.py = py;
    it.pz = pz;
    it.scale = sc;
    it.mnx = mnx;
    it.mny = mny;
    it.mnz = mnz;
    it.mxx = mxx;
    it.mxy = mxy;
    it.mxz = mxz;
    it.last = lst;
    return it;
  endfunction

  function automatic acol_pkg::res_t point(input logic signed [31:0] x,
                                           input logic signed [31:0] y,
                                           input logic signed [31:0] z, input logic c);
    return {x, y, z, c};
  endfunction

  function automatic void add_row(input query_item_t it, input bit typed = 1'b0,
                                  input acol_pkg::res_t want = '0);
    directed_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Mostly small coordinates so that boxes and points meet, with extremes
  // and full-range values mixed in.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 19))
      0: return S_MAX;
      1: return S_MIN;
      2, 3, 4: return $urandom();
      default: return int'($urandom_range(0, 40000)) - 20000;
    endcase
  endfunction

  // Gap lengths shared by both sides: mostly none or short, a few long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one item, waits for its transfer, records the prediction and
  // then leaves a gap on the input side.
  task automatic offer_item(input query_item_t it, input bit typed = 1'b0,
                            input acol_pkg::res_t want = '0);
    bit             emits;
    acol_pkg::res_t r;
    int             g;
    @(negedge clk);
    req_type  = it.kind;
    pos_x     = it.px;
    pos_y     = it.py;
    pos_z     = it.pz;
    obj_scale = it.scale;
    min_x     = it.mnx;
    min_y     = it.mny;
    min_z     = it.mnz;
    max_x     = it.mxx;
    max_y     = it.mxy;
    max_z     = it.mxz;
    last      = it.last;
    push      = 1'b1;
    do @(posedge clk); while (full);
    items_sent++;
    step_pushout(it, emits, r);
    if (emits) expected_points.insert(expected_points.size(), typed ? want : r);
    if (sender_burst > 0) begin
      sender_burst--;
      g = 0;
    end else begin
      g = idle_length();
      if ($urandom_range(0, 99) < 2) sender_burst = $urandom_range(20, 60);
    end
    if (g > 0) begin
      @(negedge clk);
      push = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // Lets every outstanding result drain before the radius is touched.
  task automatic wait_quiet();
    @(negedge clk);
    push = 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic write_radius(input logic [15:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = RADIUS_ADDR;
    // Upper bits carry noise; only the low 16 bits belong to the register.
    pwdata = {16'($urandom()), value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    radius = value;
    radius_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_radius_readback();
    logic [31:0] got;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = RADIUS_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (got !== 32'(radius))
      note_mismatch("player_radius readback", longint'(radius), longint'(got));
  endtask

  // One phase of random queries. Most of them are well-formed: a start item
  // and a handful of boxes placed around the target so that push-outs chain.
  // The rest is noise: unrelated items of any kind, objects with no start,
  // and queries that never close.
  task automatic random_phase(input int n_items);
    query_item_t it;
    logic signed [31:0] tx, ty, tz;
    logic signed [31:0] t;
    int sent;
    int n;
    int r;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          it = mk_item(acol_pkg::kind_t'($urandom_range(0, 1)), $urandom(), $urandom(),
                       $urandom(), 16'($urandom()), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom(), 1'($urandom()));
          offer_item(it);
          sent++;
        end
      end else begin
        tx = rand_coord();
        ty = rand_coord();
        tz = rand_coord();
        // A start item now and then closes the query itself.
        it = mk_item(acol_pkg::KIND_START, tx, ty, tz, 16'($urandom()), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     ($urandom_range(0, 9) == 0));
        offer_item(it);
        sent++;
        n = $urandom_range(1, 6);
        for (int j = 0; j < n; j++) begin
          it.kind = acol_pkg::KIND_OBJECT;
          it.px = 32'(clamp_q23(longint'(tx) + $urandom_range(0, 3000) - 1500));
          it.py = 32'(clamp_q23(longint'(ty) + $urandom_range(0, 3000) - 1500));
          it.pz = 32'(clamp_q23(longint'(tz) + $urandom_range(0, 3000) - 1500));
          r = $urandom_range(0, 99);
          if (r < 70) it.scale = 16'($urandom_range(192, 512));
          else if (r < 85) it.scale = 16'($urandom());
          else if (r < 92) it.scale = 16'h0000;
          else it.scale = 16'hFFFF;
          it.mnx = -int'($urandom_range(0, 2000));
          it.mny = -int'($urandom_range(0, 2000));
          it.mnz = -int'($urandom_range(0, 2000));
          it.mxx = $urandom_range(0, 2000);
          it.mxy = $urandom_range(0, 2000);
          it.mxz = $urandom_range(0, 2000);
          // Some models list their corners the wrong way round.
          if ($urandom_range(0, 9) == 0) begin
            t = it.mnx;
            it.mnx = it.mxx;
            it.mxx = t;
          end
          if ($urandom_range(0, 19) == 0) it.mny = rand_coord();
          if ($urandom_range(0, 19) == 0) it.mxz = rand_coord();
          it.last = (j == n - 1);
          offer_item(it);
          sent++;
        end
      end
    end
    // Close the phase with a start that reports, so that every item before
    // it is known to be through the block once that result arrives.
    it = mk_item(acol_pkg::KIND_START, rand_coord(), rand_coord(), rand_coord(),
                 16'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), 1'b1);
    offer_item(it);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Result side: pop is driven at the falling edge with random gaps, stretches
  // of steady popping, and one long hold-off once some results have been
  // seen. During the hold-off the sender keeps offering, so both internal
  // queues fill and full must rise.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    int stream_left;
    int gap_left;
    bit held;
    hold_left = 0;
    stream_left = 0;
    gap_left = 0;
    held = 1'b0;
    pop = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else if (!held && results_seen >= 40) begin
        held = 1'b1;
        hold_left = HOLD_OFF_CYCLES - 1;
        pop = 1'b0;
      end else if (stream_left > 0) begin
        pop = 1'b1;
        stream_left--;
      end else if (gap_left > 0) begin
        pop = 1'b0;
        gap_left--;
      end else begin
        pop = 1'b1;
        if ($urandom_range(0, 99) < 3) stream_left = $urandom_range(50, 200);
        else gap_left = idle_length();
      end
    end
  end

  // Every result transfer is compared field by field with the oldest
  // outstanding prediction.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      results_seen++;
      if (collided) hits_seen++;
      if (expected_points.size() == 0) begin
        note_mismatch("result with nothing outstanding, adj_x", 0, longint'(adj_x));
      end else begin
        acol_pkg::res_t want;
        want = expected_points.pop_front();
        if (adj_x !== want.adj_x)
          note_mismatch("adj_x", longint'(want.adj_x), longint'(adj_x));
        if (adj_y !== want.adj_y)
          note_mismatch("adj_y", longint'(want.adj_y), longint'(adj_y));
        if (adj_z !== want.adj_z)
          note_mismatch("adj_z", longint'(want.adj_z), longint'(adj_z));
        if (collided !== want.collided)
          note_mismatch("collided", longint'(want.collided), longint'(collided));
      end
    end
  end

  // Watchdog: any cycle that moves nothing counts towards the limit.
  always @(posedge clk) begin
    if (push && full) saw_full <= 1'b1;
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", expected_points.size());
        $display("aabb_pushout_collision verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] radius_plan[6];

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    push = 1'b0;
    req_type = acol_pkg::KIND_START;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    obj_scale = '0;
    min_x = '0;
    min_y = '0;
    min_z = '0;
    max_x = '0;
    max_y = '0;
    max_z = '0;
    last = 1'b0;

    // Directed rows, all under the radius left by reset (128, half a unit).
    // An object before any start tests the origin; this box lies far away.
    add_row(mk_item(acol_pkg::KIND_OBJECT, 5000, 5000, 5000, 256, -100, -100, -100,
                    100, 100, 100, 1'b1), 1'b1, point(0, 0, 0, 1'b0));
    // A plain query: two hits in a row, the second box with swapped corners,
    // then a box that misses on y as well as on z.
    add_row(mk_item(acol_pkg::KIND_START, 1000, 2000, -3000, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    add_row(mk_item(acol_pkg::KIND_OBJECT, 1000, 2000, -3000, 256, -500, -400, -100,
                    600, 300, 100, 1'b0));
    add_row(mk_item(acol_pkg::KIND_OBJECT, 800, 2100, -3000, 384, 400, 300, 200,
                    -400, -300, -200, 1'b0));
    add_row(mk_item(acol_pkg::KIND_OBJECT, 1000, 2000, 9000, 256, -500, -500, -500,
                    500, 500, 500, 1'b1));
    // A start that reports at once returns its own target, not collided.
    add_row(mk_item(acol_pkg::KIND_START, S_MAX, S_MAX, S_MAX, 16'hFFFF, S_MAX, S_MAX,
                    S_MAX, S_MAX, S_MAX, S_MAX, 1'b1), 1'b1,
            point(S_MAX, S_MAX, S_MAX, 1'b0));
    add_row(mk_item(acol_pkg::KIND_START, S_MIN, S_MIN, S_MIN, 0, S_MIN, S_MIN, S_MIN,
                    S_MIN, S_MIN, S_MIN, 1'b1), 1'b1, point(S_MIN, S_MIN, S_MIN, 1'b0));
    // The point is kept after a result. A zero-scale box at the most negative
    // corner contains it, and pushing left saturates.
    add_row(mk_item(acol_pkg::KIND_OBJECT, S_MIN, S_MIN, S_MIN, 0, 0, 0, 0, 0, 0, 0,
                    1'b1), 1'b1, point(S_MIN, S_MIN, S_MIN, 1'b1));
    // A four-way tie at the centre of a radius-only box goes to the left face.
    add_row(mk_item(acol_pkg::KIND_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    add_row(mk_item(acol_pkg::KIND_OBJECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1,
            point(-131, 0, 0, 1'b1));
    // The right, back and front faces each win once.
    add_row(mk_item(acol_pkg::KIND_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    add_row(mk_item(acol_pkg::KIND_OBJECT, -10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    add_row(mk_item(acol_pkg::KIND_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    add_row(mk_item(acol_pkg::KIND_OBJECT, 0, 10, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    add_row(mk_item(acol_pkg::KIND_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    add_row(mk_item(acol_pkg::KIND_OBJECT, 0, -10, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    // Largest scale on the widest model: every corner saturates.
    add_row(mk_item(acol_pkg::KIND_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    add_row(mk_item(acol_pkg::KIND_OBJECT, 0, 0, 0, 16'hFFFF, S_MIN, S_MIN, S_MIN,
                    S_MAX, S_MAX, S_MAX, 1'b1));
    // A point exactly on a grown face still counts as inside.
    add_row(mk_item(acol_pkg::KIND_START, 128, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    add_row(mk_item(acol_pkg::KIND_OBJECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    // Without a new start the pushed point and the hit flag carry on.
    add_row(mk_item(acol_pkg::KIND_OBJECT, 200, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    // A push past the most positive face saturates.
    add_row(mk_item(acol_pkg::KIND_START, S_MAX - 10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    add_row(mk_item(acol_pkg::KIND_OBJECT, S_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));

    radius_plan = '{16'd0, 16'hFFFF, 16'($urandom()), 16'd1, 16'($urandom()),
                    RADIUS_AT_RESET};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The register must read back its reset value before anything is written.
    check_radius_readback();
    foreach (directed_rows[i])
      offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // Random phases, each under its own radius; the block is drained before
    // every register write.
    foreach (radius_plan[p]) begin
      wait_quiet();
      write_radius(radius_plan[p]);
      check_radius_readback();
      random_phase(RANDOM_ITEMS_PER_PHASE);
    end

    wait_quiet();
    $display("Sent %0d items over %0d radius settings; checked %0d results, %0d collided.",
             items_sent, radius_writes + 1, results_seen, hits_seen);
    $display("Input back-pressure was %0s during the result hold-off.",
             saw_full ? "seen" : "not seen");
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("aabb_pushout_collision verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("aabb_pushout_collision verification failed");
    end
    $finish;
  end

endmodule
